// ----- rtl/core/pipc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-polygon package
// Shared widths, codes, payload words and the control and status words
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pipc_pkg;

   // Fixed field widths.
   localparam int COORD_WIDTH      = 16;
   localparam int INDEX_W          = 6;
   localparam int VCOUNT_W         = 7;
   localparam int CROSS_W          = 7;
   localparam int MAX_VERTICES_DEF = 64;

   // Opcodes of a request word.
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Register index on the control port (address bit 2).
   localparam logic CSR_VERTEX_COUNT = 1'b0;

   typedef struct packed {
      logic                          opcode;
      logic [INDEX_W-1:0]            vertex_index;
      logic signed [COORD_WIDTH-1:0] coord_x;
      logic signed [COORD_WIDTH-1:0] coord_y;
   } pipc_req_type;

   typedef struct packed {
      logic               inside_res;
      logic [CROSS_W-1:0] crossing_count;
   } pipc_rsp_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
   } pipc_vertex_type;

   typedef struct packed {
      logic wr_en;        // write the request vertex into the store
      logic rd_en;        // read one vertex from the store
      logic rd_first;     // the vertex read is vertex zero
      logic start_query;  // latch the test point and clear the count
      logic close_edge;   // push the closing edge, last vertex to first
      logic load_result;  // move the count into the output register
   } pipc_cmd_type;

   typedef struct packed {
      logic pipe_busy;    // an edge is still in the compare pipeline
   } pipc_status_type;

endpackage

// ----- rtl/core/point_in_polygon_crossing.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-polygon crossing-number test
// Loads polygon vertices into a store and answers point queries with the
// crossing count and its parity.
//
//   Channel   Direction  Handshake           Word
//   req_      in         req_valid/stall     opcode, vertex_index, x, y
//   rsp_      out        rsp_valid/stall     inside_res, crossing_count
//   csr       in/out     APB psel/penable    vertex_count at address 0
//
// A query walks the n vertices in order: the vertex memory's single read
// port delivers one vertex, and so one edge, per cycle, and the drain then
// waits until the last edges have left the compare pipeline. A query with
// fewer than three vertices skips the walk and goes straight to the result.
// Reset is synchronous and clears the vertex count; the vertex store is
// not cleared. A stalled response holds its word, while loads are still
// accepted; a further query finishes only after that word is taken.
// ----------------------------------------------------------------------------
module point_in_polygon_crossing #(
   parameter int MAX_VERTICES = pipc_pkg::MAX_VERTICES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  pipc_pkg::pipc_req_type req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output pipc_pkg::pipc_rsp_type rsp_payload,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [2:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   import pipc_pkg::*;

   localparam int ADDR_W = $clog2(MAX_VERTICES);

   logic [VCOUNT_W-1:0] vertex_count_ff, vertex_count_in;
   logic                csr_write;
   logic                csr_sel_count;
   pipc_cmd_type        cmd;
   pipc_status_type     status;
   logic [ADDR_W-1:0]   rd_addr;

   // Control register port; address bits 1:0 are byte lanes.
   assign pready        = 1'b1;
   assign csr_sel_count = (paddr[2] == CSR_VERTEX_COUNT);
   assign csr_write     = psel && penable && pwrite && pready;

   always_comb begin
      vertex_count_in = vertex_count_ff;
      if (csr_write && csr_sel_count) begin
         vertex_count_in = pwdata[VCOUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= '0;
      end else begin
         vertex_count_ff <= vertex_count_in;
      end
   end

   assign prdata = csr_sel_count ? 32'(vertex_count_ff) : '0;

   // Controller.
   pipc_ctrl #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_opcode   (req_payload.opcode),
      .req_stall    (req_stall),
      .vertex_count (vertex_count_ff),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .status       (status),
      .cmd          (cmd),
      .rd_addr      (rd_addr)
   );

   // Datapath.
   pipc_datapath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .rd_addr     (rd_addr),
      .req_payload (req_payload),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- rtl/core/pipc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pipc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/pipc_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-polygon datapath
// Holds the vertex store, forms one edge per cycle, tests it against the
// test point with an exact cross-multiplication and counts crossings.
// ----------------------------------------------------------------------------
module pipc_datapath #(
   parameter int MAX_VERTICES = pipc_pkg::MAX_VERTICES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  pipc_pkg::pipc_cmd_type          cmd,
   input  logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
   input  pipc_pkg::pipc_req_type          req_payload,
   output pipc_pkg::pipc_status_type       status,
   output pipc_pkg::pipc_rsp_type          rsp_payload
);
   import pipc_pkg::*;

   localparam int ADDR_W = $clog2(MAX_VERTICES);
   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int SAT_W  = (CNT_W > CROSS_W) ? CNT_W : CROSS_W;
   localparam int DIFF_W = COORD_WIDTH + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int VTX_W  = 2 * COORD_WIDTH;

   logic                     slot_ok;
   logic                     ram_we;
   pipc_vertex_type          wr_vertex;
   logic [VTX_W-1:0]         rd_data;
   pipc_vertex_type          rd_vertex;

   logic                     rdv_ff;
   logic                     rdfirst_ff;
   pipc_vertex_type          first_ff;
   pipc_vertex_type          prev_ff;
   logic signed [COORD_WIDTH-1:0] px_ff;
   logic signed [COORD_WIDTH-1:0] py_ff;

   logic                     push;
   pipc_vertex_type          edge_start;
   pipc_vertex_type          edge_end;
   logic                     up;
   logic                     down;
   logic                     hit;
   logic signed [DIFF_W-1:0] dy;
   logic signed [DIFF_W-1:0] dxp;
   logic signed [DIFF_W-1:0] dxe;
   logic signed [DIFF_W-1:0] dyp;

   logic                     a_valid_ff;
   logic                     a_up_ff;
   logic signed [DIFF_W-1:0] a_dy_ff;
   logic signed [DIFF_W-1:0] a_dxp_ff;
   logic signed [DIFF_W-1:0] a_dxe_ff;
   logic signed [DIFF_W-1:0] a_dyp_ff;

   logic                     b_valid_ff;
   logic                     b_up_ff;
   logic signed [PROD_W-1:0] b_lhs_ff;
   logic signed [PROD_W-1:0] b_rhs_ff;

   logic                     crossing;
   logic [CNT_W-1:0]         count_ff;
   logic [SAT_W-1:0]         count_wide;
   logic [CROSS_W-1:0]       count_sat;
   pipc_rsp_type             rsp_ff;

   // Vertex store write: loads beyond the store are dropped.
   assign slot_ok     = int'(req_payload.vertex_index) < MAX_VERTICES;
   assign ram_we      = cmd.wr_en && slot_ok;
   assign wr_vertex.x = req_payload.coord_x;
   assign wr_vertex.y = req_payload.coord_y;

   pipc_ram #(
      .WIDTH (VTX_W),
      .DEPTH (MAX_VERTICES)
   ) u_vertex_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ADDR_W'(req_payload.vertex_index)),
      .wr_data (wr_vertex),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_vertex = pipc_vertex_type'(rd_data);

   // Read data arrives in the cycle after the read command.
   always_ff @(posedge clock) begin
      if (reset) begin
         rdv_ff <= 1'b0;
      end else begin
         rdv_ff <= cmd.rd_en;
      end
      rdfirst_ff <= cmd.rd_first;
   end

   // Test point, first vertex and previous vertex.
   always_ff @(posedge clock) begin
      if (cmd.start_query) begin
         px_ff <= req_payload.coord_x;
         py_ff <= req_payload.coord_y;
      end
      if (rdv_ff) begin
         prev_ff <= rd_vertex;
         if (rdfirst_ff) begin
            first_ff <= rd_vertex;
         end
      end
   end

   // Edge selection: a fresh vertex closes an edge from the previous one,
   // and the closing command pairs the last vertex with vertex zero.
   assign push       = (rdv_ff && !rdfirst_ff) || cmd.close_edge;
   assign edge_start = prev_ff;
   assign edge_end   = cmd.close_edge ? first_ff : rd_vertex;

   // Half-open span test and the differences for the crossing position.
   always_comb begin
      dy   = DIFF_W'(edge_end.y) - DIFF_W'(edge_start.y);
      dxp  = DIFF_W'(px_ff) - DIFF_W'(edge_start.x);
      dxe  = DIFF_W'(edge_end.x) - DIFF_W'(edge_start.x);
      dyp  = DIFF_W'(py_ff) - DIFF_W'(edge_start.y);
      up   = edge_end.y > edge_start.y;
      down = edge_end.y < edge_start.y;
      hit  = (up && (edge_start.y <= py_ff) && (py_ff < edge_end.y)) ||
             (down && (edge_start.y > py_ff) && (py_ff >= edge_end.y));
   end

   // Stage A: edges that span the point's row.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= push && hit;
      end
      a_up_ff  <= up;
      a_dy_ff  <= dy;
      a_dxp_ff <= dxp;
      a_dxe_ff <= dxe;
      a_dyp_ff <= dyp;
   end

   // Stage B: the two cross products.
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_up_ff  <= a_up_ff;
      b_lhs_ff <= a_dxp_ff * a_dy_ff;
      b_rhs_ff <= a_dxe_ff * a_dyp_ff;
   end

   // Stage C: the crossing is right of the point when the products order
   // the same way as the edge direction says.
   assign crossing = b_valid_ff &&
                     ((b_up_ff && (b_lhs_ff < b_rhs_ff)) ||
                      (!b_up_ff && (b_lhs_ff > b_rhs_ff)));

   always_ff @(posedge clock) begin
      if (cmd.start_query) begin
         count_ff <= '0;
      end else if (crossing) begin
         count_ff <= count_ff + CNT_W'(1);
      end
   end

   // Output register, count saturated to the field width.
   assign count_wide = SAT_W'(count_ff);
   assign count_sat  = (count_wide > SAT_W'({CROSS_W{1'b1}})) ?
                       {CROSS_W{1'b1}} : count_wide[CROSS_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         rsp_ff.inside_res     <= count_ff[0];
         rsp_ff.crossing_count <= count_sat;
      end
   end

   assign rsp_payload      = rsp_ff;
   assign status.pipe_busy = a_valid_ff || b_valid_ff;

endmodule

// ----- rtl/core/pipc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-polygon controller
// Accepts request words, sequences the vertex walk of a query and hands
// the result to the response channel.
// ----------------------------------------------------------------------------
module pipc_ctrl #(
   parameter int MAX_VERTICES = pipc_pkg::MAX_VERTICES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_opcode,
   output logic                              req_stall,
   input  logic [pipc_pkg::VCOUNT_W-1:0]     vertex_count,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  pipc_pkg::pipc_status_type         status,
   output pipc_pkg::pipc_cmd_type            cmd,
   output logic [$clog2(MAX_VERTICES)-1:0]   rd_addr
);
   import pipc_pkg::*;

   localparam int ADDR_W  = $clog2(MAX_VERTICES);
   localparam int NCNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int VC_W    = (NCNT_W > VCOUNT_W) ? NCNT_W : VCOUNT_W;
   localparam int STATE_W = 3;

   localparam logic [STATE_W-1:0] S_IDLE   = 3'd0;
   localparam logic [STATE_W-1:0] S_WALK   = 3'd1;
   localparam logic [STATE_W-1:0] S_TAIL   = 3'd2;
   localparam logic [STATE_W-1:0] S_CLOSE  = 3'd3;
   localparam logic [STATE_W-1:0] S_DRAIN  = 3'd4;
   localparam logic [STATE_W-1:0] S_FINISH = 3'd5;

   logic [STATE_W-1:0] state_ff, state_in;
   logic [NCNT_W-1:0]  n_ff, n_in;
   logic [NCNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               accept;
   logic [VC_W-1:0]    vc_wide;
   logic [VC_W-1:0]    vc_clamp;
   logic [NCNT_W-1:0]  n_clamp;
   logic               out_free;

   // A count above the store size uses the whole store.
   assign vc_wide  = VC_W'(vertex_count);
   assign vc_clamp = (vc_wide > VC_W'(MAX_VERTICES)) ? VC_W'(MAX_VERTICES) : vc_wide;
   assign n_clamp  = NCNT_W'(vc_clamp);

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rd_addr   = rd_idx_ff[ADDR_W-1:0];

   // Next-state and command logic.
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      rd_idx_in    = rd_idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_opcode == OP_LOAD) begin
                  cmd.wr_en = 1'b1;
               end else begin
                  cmd.start_query = 1'b1;
                  n_in            = n_clamp;
                  rd_idx_in       = '0;
                  state_in        = (n_clamp >= NCNT_W'(3)) ? S_WALK : S_FINISH;
               end
            end
         end
         S_WALK: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_first = (rd_idx_ff == '0);
            rd_idx_in    = rd_idx_ff + NCNT_W'(1);
            if (rd_idx_ff == n_ff - NCNT_W'(1)) begin
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            state_in = S_CLOSE;
         end
         S_CLOSE: begin
            cmd.close_edge = 1'b1;
            state_in       = S_DRAIN;
         end
         S_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.load_result = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         n_ff         <= '0;
         rd_idx_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         n_ff         <= n_in;
         rd_idx_ff    <= rd_idx_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   // Reads stay inside the vertices in use.
   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> (rd_idx_ff < n_ff))
      else $error("vertex read beyond the vertex count");

   // No edge is left in the compare pipeline once the block is idle.
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !status.pipe_busy)
      else $error("compare pipeline busy while idle");

   // A result appears only when the walk has finished.
   a_result_after_walk: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("result raised outside the finish step");

   // A new result never overwrites one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_result |-> !(rsp_valid_ff && rsp_stall))
      else $error("result overwritten while stalled");
`endif

endmodule

// ----- tb/sv/point_in_polygon_crossing_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-polygon crossing checker
// Watches the request, response and control ports of the crossing block,
// keeps its own vertex store and vertex count, works out the answer of every
// accepted query word and compares each response word with the oldest
// answer still waiting. Register reads are checked against the count.
// ----------------------------------------------------------------------------
module point_in_polygon_crossing_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  pipc_pkg::pipc_req_type req_payload,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  pipc_pkg::pipc_rsp_type rsp_payload,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [2:0]             paddr,
   input  logic [31:0]            pwdata,
   input  logic [31:0]            prdata,
   input  logic                   pready,
   output int                     failures,
   output int                     awaiting,
   output int                     checked
);
   import pipc_pkg::*;

   // Shadow copy of the polygon and the vertex count.
   logic signed [COORD_WIDTH-1:0] shadow_x [MAX_VERTICES_DEF];
   logic signed [COORD_WIDTH-1:0] shadow_y [MAX_VERTICES_DEF];
   logic [VCOUNT_W-1:0]           shadow_count;

   // Answers of accepted queries, oldest first.
   pipc_rsp_type answer_q [$];

   initial begin
      failures = 0;
      awaiting = 0;
      checked  = 0;
      shadow_count = '0;
   end

   // Walks every edge, closing edge included, and counts the crossings
   // strictly to the right of the test point. The crossing position is
   // compared exactly by scaling both sides with the edge height.
   function automatic pipc_rsp_type count_crossings(
      input logic signed [COORD_WIDTH-1:0] test_x,
      input logic signed [COORD_WIDTH-1:0] test_y
   );
      int           edges;
      int           nxt;
      int           hits;
      longint       qx, qy, xs, ys, xe, ye, dy, lhs, rhs;
      bit           spans;
      pipc_rsp_type answer;
      edges = shadow_count;
      if (edges > MAX_VERTICES_DEF)
         edges = MAX_VERTICES_DEF;
      hits = 0;
      qx = test_x;
      qy = test_y;
      if (edges >= 3) begin
         for (int i = 0; i < edges; i++) begin
            nxt = (i == edges - 1) ? 0 : i + 1;
            xs = shadow_x[i];
            ys = shadow_y[i];
            xe = shadow_x[nxt];
            ye = shadow_y[nxt];
            dy = ye - ys;
            if (dy != 0) begin
               // Upward edges hold their start row, downward edges their end row.
               if (dy > 0)
                  spans = (ys <= qy) && (qy < ye);
               else
                  spans = (ys > qy) && (qy >= ye);
               if (spans) begin
                  lhs = (qx - xs) * dy;
                  rhs = (xe - xs) * (qy - ys);
                  if ((dy > 0 && lhs < rhs) || (dy < 0 && lhs > rhs))
                     hits++;
               end
            end
         end
      end
      answer.inside_res     = hits[0];
      answer.crossing_count = (hits > 127) ? 7'd127 : hits[CROSS_W-1:0];
      return answer;
   endfunction

   // Counts a failure and reports it while the report budget lasts.
   task automatic flag_failure(input string what);
      if (failures < 10)
         $display("[%0t] MISMATCH: %s", $realtime, what);
      failures++;
   endtask

   // Sample all three ports at each rising edge.
   always @(posedge clock) begin : watch
      pipc_rsp_type want;
      if (reset) begin
         shadow_count = '0;
         answer_q.delete();
         awaiting <= 0;
      end else begin
         // A response word is checked against the oldest answer.
         if (rsp_valid && !rsp_stall) begin
            checked++;
            if (answer_q.size() == 0) begin
               flag_failure($sformatf("response word (inside %0b, count %0d) with no query waiting",
                                      rsp_payload.inside_res, rsp_payload.crossing_count));
            end else begin
               want = answer_q.pop_front();
               if (rsp_payload.inside_res !== want.inside_res ||
                   rsp_payload.crossing_count !== want.crossing_count)
                  flag_failure($sformatf(
                     "result %0d: expected inside %0b count %0d, got inside %0b count %0d",
                     checked, want.inside_res, want.crossing_count,
                     rsp_payload.inside_res, rsp_payload.crossing_count));
            end
         end

         // A request word either stores a vertex or queues an answer.
         if (req_valid && !req_stall) begin
            if (req_payload.opcode == OP_LOAD) begin
               shadow_x[req_payload.vertex_index] = req_payload.coord_x;
               shadow_y[req_payload.vertex_index] = req_payload.coord_y;
            end else begin
               answer_q.push_back(count_crossings(req_payload.coord_x, req_payload.coord_y));
            end
         end

         // Register writes update the count; reads must return it.
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr[2] == CSR_VERTEX_COUNT)
                  shadow_count = pwdata[VCOUNT_W-1:0];
            end else if (prdata !== {{(32-VCOUNT_W){1'b0}}, shadow_count}) begin
               flag_failure($sformatf("register read: expected %0d, got %0h",
                                      shadow_count, prdata));
            end
         end

         awaiting <= answer_q.size();
      end
   end

endmodule

// ----- tb/sv/point_in_polygon_crossing_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-polygon crossing testbench
// Loads polygons of sizes from none to above the store size, queries
// test points on edges, corners and at random, and runs the traffic under
// several idle and stall mixes, one long response hold among them. A
// separate checker predicts every answer and counts the failures.
// ----------------------------------------------------------------------------
module point_in_polygon_crossing_tb;
   import pipc_pkg::*;

   localparam int  DRAIN      = MAX_VERTICES_DEF + 16;
   localparam int  HOLD_LEN   = 3000;
   localparam int  CYCLE_MAX  = 1000000;
   localparam int  WORD_GOAL  = 1050;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   pipc_req_type req_payload = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   pipc_rsp_type rsp_payload;
   logic         psel = 1'b0;
   logic         penable = 1'b0;
   logic         pwrite = 1'b0;
   logic [2:0]   paddr = '0;
   logic [31:0]  pwdata = '0;
   logic [31:0]  prdata;
   logic         pready;

   int failures;
   int awaiting;
   int checked;

   // Stimulus bookkeeping.
   int words_sent   = 0;
   int queries_sent = 0;
   int send_pct     = 0;
   int recv_pct     = 0;
   int hold_token   = 0;
   int cycles       = 0;
   logic signed [COORD_WIDTH-1:0] placed_x [MAX_VERTICES_DEF];
   logic signed [COORD_WIDTH-1:0] placed_y [MAX_VERTICES_DEF];

   point_in_polygon_crossing DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   point_in_polygon_crossing_checker u_answers (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .failures    (failures),
      .awaiting    (awaiting),
      .checked     (checked)
   );

   // Clock generation.
   initial begin
      forever #10 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_MAX) begin
         $display("Run limit of %0d cycles reached with %0d answers waiting",
                  CYCLE_MAX, awaiting);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Response side: random stalls, or a long hold when one is requested.
   always @(posedge clock) begin : receiver
      int hold_left;
      int hold_seen;
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = HOLD_LEN;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_pct);
      end
   end

   // Random coordinate within +/- span, or over the full range for span 0.
   function automatic logic signed [COORD_WIDTH-1:0] pick_coord(input int span);
      if (span == 0)
         return COORD_WIDTH'($urandom);
      return COORD_WIDTH'($urandom_range(2 * span) - span);
   endfunction

   // Offers one request word after a random gap and waits until it is taken.
   task automatic send_word(input logic op, input logic [INDEX_W-1:0] slot,
                            input logic signed [COORD_WIDTH-1:0] x,
                            input logic signed [COORD_WIDTH-1:0] y);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{opcode: op, vertex_index: slot, coord_x: x, coord_y: y};
      do @(posedge clock); while (req_stall);
      words_sent++;
      if (op == OP_QUERY) begin
         queries_sent++;
      end else begin
         placed_x[slot] = x;
         placed_y[slot] = y;
      end
   endtask

   // Waits until every answer is back and the block has had time to settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaiting != 0);
      repeat (DRAIN) @(posedge clock);
   endtask

   // One control port transfer; psel stays up for a following transfer.
   task automatic csr_access(input logic wr, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {CSR_VERTEX_COUNT, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
   endtask

   // Writes the vertex count while idle and reads it back.
   task automatic set_vertex_count(input int count);
      wait_idle();
      csr_access(1'b1, count);
      csr_access(1'b0, 32'd0);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Main stimulus.
   initial begin : stimulus
      int size;
      int span;
      int loads;
      int pick;
      int phase;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty polygon, then a square on the coordinate extremes.
      send_word(OP_QUERY, 6'd0, 16'sd0, 16'sd0);
      send_word(OP_LOAD, 6'd0, -16'sd32768, -16'sd32768);
      send_word(OP_LOAD, 6'd1, 16'sd32767, -16'sd32768);
      send_word(OP_LOAD, 6'd2, 16'sd32767, 16'sd32767);
      send_word(OP_LOAD, 6'd3, -16'sd32768, 16'sd32767);
      send_word(OP_LOAD, 6'd63, 16'sd32767, -16'sd1);
      // Two vertices are not a polygon.
      set_vertex_count(2);
      send_word(OP_QUERY, 6'd63, 16'sd0, 16'sd0);
      set_vertex_count(4);
      send_word(OP_QUERY, 6'd0, 16'sd0, 16'sd0);
      send_word(OP_QUERY, 6'd63, -16'sd32768, -16'sd32768);
      send_word(OP_QUERY, 6'd21, 16'sd32767, 16'sd32767);
      send_word(OP_QUERY, 6'd42, -16'sd32768, 16'sd0);
      send_word(OP_QUERY, 6'd0, 16'sd32767, 16'sd0);
      send_word(OP_QUERY, 6'd0, 16'sd0, -16'sd32768);
      send_word(OP_QUERY, 6'd0, 16'sd0, 16'sd32767);
      send_word(OP_QUERY, 6'd63, -16'sd1, -16'sd1);
      // Triangle with a horizontal base: points on the base, at the apex.
      send_word(OP_LOAD, 6'd0, 16'sd0, 16'sd0);
      send_word(OP_LOAD, 6'd1, 16'sd10, 16'sd0);
      send_word(OP_LOAD, 6'd2, 16'sd5, 16'sd10);
      set_vertex_count(3);
      send_word(OP_QUERY, 6'd0, 16'sd5, 16'sd0);
      send_word(OP_QUERY, 6'd0, 16'sd5, 16'sd10);
      send_word(OP_QUERY, 6'd0, -16'sd5, 16'sd5);
      send_word(OP_QUERY, 6'd0, 16'sd5, 16'sd5);

      // Random phases: load a fresh polygon, set its size, then mixed traffic.
      phase = 0;
      while (words_sent < WORD_GOAL) begin
         case (phase)
            0:       size = 127;
            1:       size = 64;
            2:       size = 3;
            3:       size = 0;
            4:       size = 1;
            5:       size = 2;
            default: size = ($urandom_range(7) == 0) ? $urandom_range(13, 64)
                                                      : $urandom_range(3, 12);
         endcase
         case ($urandom_range(3))
            0:       span = 8;
            1:       span = 200;
            2:       span = 20000;
            default: span = 0;
         endcase
         wait_idle();
         case (phase % 4)
            0: begin send_pct = 0;  recv_pct = 0;  end
            1: begin send_pct = 47; recv_pct = 0;  end
            2: begin send_pct = 0;  recv_pct = 47; end
            default: begin send_pct = 29; recv_pct = 29; end
         endcase
         loads = (size > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : size;
         for (int i = 0; i < loads; i++)
            send_word(OP_LOAD, INDEX_W'(i), pick_coord(span), pick_coord(span));
         set_vertex_count(size);

         // Hold the response side off while queries keep coming.
         if (phase == 2) begin
            hold_token++;
            for (int i = 0; i < 24; i++)
               send_word(OP_QUERY, INDEX_W'($urandom), pick_coord(span), pick_coord(span));
         end

         for (int i = 0; i < 36; i++) begin
            pick = $urandom_range(99);
            if (pick < 14 && loads > 0) begin
               // Query exactly on a stored vertex.
               pick = $urandom_range(loads - 1);
               send_word(OP_QUERY, INDEX_W'($urandom), placed_x[pick], placed_y[pick]);
            end else if (pick < 70) begin
               send_word(OP_QUERY, INDEX_W'($urandom), pick_coord(span), pick_coord(span));
            end else begin
               send_word(OP_LOAD, INDEX_W'($urandom), pick_coord(span), pick_coord(span));
            end
         end
         phase++;
      end

      // Drain and give the verdict.
      wait_idle();
      $display("Summary: %0d request words (%0d queries) over %0d phases, %0d answers checked.",
               words_sent, queries_sent, phase, checked);
      $display("Polygons of 0 to 127 vertices under four idle mixes and one long response hold.");
      if (failures == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/pipc_pkg.sv
rtl/core/pipc_ram.sv
rtl/core/pipc_datapath.sv
rtl/core/pipc_ctrl.sv
rtl/core/point_in_polygon_crossing.sv
tb/sv/point_in_polygon_crossing_checker.sv
tb/sv/point_in_polygon_crossing_tb.sv
